### hw/rtl/tfec_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and byte-swap helpers for the texture file endian converter.
// No dependencies.
package tfec_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 30;
   localparam int STAT_W  = 3;

   localparam logic [WORD_W-1:0] MAGIC_WORD = 32'h0000_0010;
   localparam int                COLOR_BIT  = 3;
   localparam logic [WORD_W-1:0] MIN_BLOCK  = 32'd12;
   localparam logic [COUNT_W-1:0] HDR_WORDS = 30'd3;

   typedef enum logic [5:0] {
      PH_PASS    = 6'b000001,
      PH_MODE    = 6'b000010,
      PH_SIZE    = 6'b000100,
      PH_RECT0   = 6'b001000,
      PH_RECT1   = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef enum logic [STAT_W-1:0] {
      ST_CONVERT = 3'd0,
      ST_IDLE    = 3'd1,
      ST_NATIVE  = 3'd2,
      ST_FOREIGN = 3'd3,
      ST_BADSIZE = 3'd4
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] raw_word;
      logic              first_word;
   } word_type;

   function automatic logic [WORD_W-1:0] swap_all(input logic [WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] v);
      return {v[23:16], v[31:24], v[7:0], v[15:8]};
   endfunction

endpackage

### hw/rtl/texture_file_endian_converter_core.sv
`timescale 1ns / 1ps
// Top level of the texture file endian converter: input stage, converter, result register.
// Depends on tfec_pkg, tfec_in_stage and tfec_convert.
//
//   channel  dir  ports                                   word
//   req      in   req_valid, req_stall, req_raw_word,     one raw file word + first flag
//                 req_first_word
//   rsp      out  rsp_valid, rsp_stall, rsp_out_word,     converted word + status
//                 rsp_status
//
// rsp_valid rises once an accepted word has passed the input register, then the result register;
// one word per cycle sustained while rsp_stall is low.
// The input register feeds the swap/phase logic, whose result lands in the output register.
// Synchronous active-high reset empties both registers and returns to idle pass-through.
// A stalled result holds; the input register keeps accepting until it is also full.
module texture_file_endian_converter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tfec_pkg::WORD_W-1:0]      req_raw_word,
   input  logic                             req_first_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tfec_pkg::WORD_W-1:0]      rsp_out_word,
   output logic [tfec_pkg::STAT_W-1:0]      rsp_status
);

   tfec_pkg::word_type           stage;
   logic                         advance;
   logic [tfec_pkg::WORD_W-1:0]  conv_word;
   tfec_pkg::status_type         conv_status;

   logic                         out_valid_ff, out_valid_in;
   logic [tfec_pkg::WORD_W-1:0]  out_word_ff;
   tfec_pkg::status_type         out_status_ff;

   assign advance = stage.valid && (!out_valid_ff || !rsp_stall);

   tfec_in_stage u_in (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_raw_word   (req_raw_word),
      .req_first_word (req_first_word),
      .advance        (advance),
      .req_stall      (req_stall),
      .stage          (stage)
   );

   tfec_convert u_conv (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage       (stage),
      .conv_word   (conv_word),
      .conv_status (conv_status)
   );

   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_word_ff   <= conv_word;
         out_status_ff <= conv_status;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_word = out_word_ff;
   assign rsp_status   = out_status_ff;

endmodule

### hw/rtl/tfec_in_stage.sv
`timescale 1ns / 1ps
// Input register for the converter: captures one word when it is free or draining.
// Depends on tfec_pkg.
module tfec_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [tfec_pkg::WORD_W-1:0]   req_raw_word,
   input  logic                          req_first_word,
   input  logic                          advance,
   output logic                          req_stall,
   output tfec_pkg::word_type            stage
);

   tfec_pkg::word_type stage_ff, stage_in;

   assign req_stall = stage_ff.valid && !advance;
   assign stage     = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (req_valid && !req_stall) begin
         stage_in.valid      = 1'b1;
         stage_in.raw_word   = req_raw_word;
         stage_in.first_word = req_first_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.raw_word   <= stage_in.raw_word;
      stage_ff.first_word <= stage_in.first_word;
   end

endmodule

### hw/rtl/tfec_convert.sv
`timescale 1ns / 1ps
// File-layout tracker and byte swapper; state moves once per word that advances.
// Depends on tfec_pkg.
module tfec_convert (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  tfec_pkg::word_type               stage,
   output logic [tfec_pkg::WORD_W-1:0]      conv_word,
   output tfec_pkg::status_type             conv_status
);

   tfec_pkg::phase_type             phase_ff, phase_in;
   logic                            in_color_ff, in_color_in;
   logic [tfec_pkg::COUNT_W-1:0]    left_ff, left_in;
   tfec_pkg::status_type            reason_ff, reason_in;
   logic [tfec_pkg::WORD_W-1:0]     sw_all, sw_half;

   assign sw_all  = tfec_pkg::swap_all(stage.raw_word);
   assign sw_half = tfec_pkg::swap_halves(stage.raw_word);

   always_comb begin
      phase_in    = phase_ff;
      in_color_in = in_color_ff;
      left_in     = left_ff;
      reason_in   = reason_ff;
      conv_word   = stage.raw_word;
      conv_status = tfec_pkg::ST_CONVERT;
      if (stage.first_word) begin
         in_color_in = 1'b0;
         left_in     = '0;
         if (stage.raw_word == tfec_pkg::MAGIC_WORD) begin
            phase_in    = tfec_pkg::PH_PASS;
            reason_in   = tfec_pkg::ST_NATIVE;
            conv_status = tfec_pkg::ST_NATIVE;
         end else if (sw_all == tfec_pkg::MAGIC_WORD) begin
            conv_word = tfec_pkg::MAGIC_WORD;
            phase_in  = tfec_pkg::PH_MODE;
         end else begin
            phase_in    = tfec_pkg::PH_PASS;
            reason_in   = tfec_pkg::ST_FOREIGN;
            conv_status = tfec_pkg::ST_FOREIGN;
         end
      end else begin
         unique case (phase_ff)
            tfec_pkg::PH_MODE: begin
               conv_word   = sw_all;
               in_color_in = sw_all[tfec_pkg::COLOR_BIT];
               phase_in    = tfec_pkg::PH_SIZE;
            end
            tfec_pkg::PH_SIZE: begin
               conv_word = sw_all;
               if (sw_all < tfec_pkg::MIN_BLOCK || sw_all[1:0] != 2'b00) begin
                  phase_in    = tfec_pkg::PH_PASS;
                  reason_in   = tfec_pkg::ST_BADSIZE;
                  conv_status = tfec_pkg::ST_BADSIZE;
               end else begin
                  left_in  = sw_all[tfec_pkg::WORD_W-1:2] - tfec_pkg::HDR_WORDS;
                  phase_in = tfec_pkg::PH_RECT0;
               end
            end
            tfec_pkg::PH_RECT0: begin
               conv_word = sw_half;
               phase_in  = tfec_pkg::PH_RECT1;
            end
            tfec_pkg::PH_RECT1: begin
               conv_word = sw_half;
               if (left_ff == '0) begin
                  if (in_color_ff) begin
                     in_color_in = 1'b0;
                     phase_in    = tfec_pkg::PH_SIZE;
                  end else begin
                     phase_in  = tfec_pkg::PH_PASS;
                     reason_in = tfec_pkg::ST_IDLE;
                  end
               end else begin
                  phase_in = tfec_pkg::PH_PAYLOAD;
               end
            end
            tfec_pkg::PH_PAYLOAD: begin
               conv_word = sw_half;
               left_in   = left_ff - 1'b1;
               if (left_ff == tfec_pkg::COUNT_W'(1)) begin
                  if (in_color_ff) begin
                     in_color_in = 1'b0;
                     phase_in    = tfec_pkg::PH_SIZE;
                  end else begin
                     phase_in  = tfec_pkg::PH_PASS;
                     reason_in = tfec_pkg::ST_IDLE;
                  end
               end
            end
            default: begin
               conv_status = reason_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tfec_pkg::PH_PASS;
         in_color_ff <= 1'b0;
         left_ff     <= '0;
         reason_ff   <= tfec_pkg::ST_IDLE;
      end else if (advance) begin
         phase_ff    <= phase_in;
         in_color_ff <= in_color_in;
         left_ff     <= left_in;
         reason_ff   <= reason_in;
      end
   end

endmodule

### hw/rtl/tfec_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the texture file endian converter, bound to the top level.
// Depends on tfec_pkg and texture_file_endian_converter_core.
module tfec_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tfec_pkg::WORD_W-1:0]      rsp_out_word,
   input logic [tfec_pkg::STAT_W-1:0]      rsp_status
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_word) && $stable(rsp_status))
      else $error("stalled result changed");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == tfec_pkg::ST_CONVERT || rsp_status == tfec_pkg::ST_IDLE
         || rsp_status == tfec_pkg::ST_NATIVE || rsp_status == tfec_pkg::ST_FOREIGN
         || rsp_status == tfec_pkg::ST_BADSIZE)
      else $error("undefined status code");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_accept_flows : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall |=> !rsp_stall || rsp_valid || !req_stall)
      else $error("pipeline lost track of an accepted word");

endmodule

bind texture_file_endian_converter_core tfec_checker u_tfec_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_word (rsp_out_word),
   .rsp_status   (rsp_status)
);
